/* hw/rtl/plld_pkg.sv */
// shared types, constants and field helpers for the distance lookup core
package plld_pkg;

  localparam int X_W       = 20;
  localparam int PT_W      = 32;
  localparam int NREGS     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * X_W;

  // reset table: widths 1000 to 2000 px in steps of 200, distances zero
  localparam logic [PT_W-1:0] PT_RESET [NREGS] = '{
    32'd65536000, 32'd78643200, 32'd91750400,
    32'd104857600, 32'd117964800, 32'd131072000
  };

  typedef struct packed {
    logic           valid;
    logic           neg;
    logic [X_W-1:0] base;
  } div_ctl_t;

  function automatic logic [X_W-1:0] pt_width(input logic [PT_W-1:0] pt);
    pt_width = {pt[31:16], 4'b0000};
  endfunction

  function automatic logic [X_W-1:0] pt_dist(input logic [PT_W-1:0] pt);
    pt_dist = {pt[15:0], 4'b0000};
  endfunction

endpackage

/* hw/rtl/plld_div.sv */
// pipelined restoring divider, one quotient bit per stage
module plld_div (
  input  logic                       clk,
  input  logic                       rst,
  input  plld_pkg::div_ctl_t         in_ctl,
  input  logic [plld_pkg::PROD_W-1:0] dividend,
  input  logic [plld_pkg::X_W-1:0]   divisor,
  output plld_pkg::div_ctl_t         out_ctl,
  output logic [plld_pkg::X_W-1:0]   quotient
);

  localparam int QW = plld_pkg::X_W;

  // element k holds the output of stage k-1
  logic [QW-1:0]      rem_q  [1:QW];
  logic [QW-1:0]      rest_q [1:QW];
  logic [QW-1:0]      quo_q  [1:QW];
  logic [QW-1:0]      div_q  [1:QW];
  plld_pkg::div_ctl_t ctl_q  [1:QW];

  genvar k;
  for (k = 0; k < QW; k++) begin : g_stage
    logic [QW-1:0]      rem_in;
    logic [QW-1:0]      rest_in;
    logic [QW-1:0]      quo_in;
    logic [QW-1:0]      div_in;
    plld_pkg::div_ctl_t ctl_in;
    logic [QW:0]        trial;
    logic               fits;

    if (k == 0) begin : g_first
      // quotient is known to fit, so the upper half is already below the divisor
      assign rem_in  = dividend[2*QW-1:QW];
      assign rest_in = dividend[QW-1:0];
      assign quo_in  = '0;
      assign div_in  = divisor;
      assign ctl_in  = in_ctl;
    end else begin : g_next
      assign rem_in  = rem_q[k];
      assign rest_in = rest_q[k];
      assign quo_in  = quo_q[k];
      assign div_in  = div_q[k];
      assign ctl_in  = ctl_q[k];
    end

    assign trial = {rem_in, rest_in[QW-1]};
    assign fits  = trial >= {1'b0, div_in};

    always_ff @(posedge clk) begin
      rem_q[k+1]  <= fits ? QW'(trial - {1'b0, div_in}) : trial[QW-1:0];
      rest_q[k+1] <= {rest_in[QW-2:0], 1'b0};
      quo_q[k+1]  <= {quo_in[QW-2:0], fits};
      div_q[k+1]  <= div_in;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[k+1] <= '0;
      end else begin
        ctl_q[k+1] <= ctl_in;
      end
    end
  end

  assign out_ctl  = ctl_q[QW];
  assign quotient = quo_q[QW];

endmodule

/* hw/rtl/piecewise_linear_distance_lookup_core.sv */
// top level: width to distance lookup with linear interpolation between calibration points
//
// One width word is taken at every clock edge with start high and busy low, and its
// distance appears on distance_q4 with done high for one cycle, after the pipeline. A new
// word may be started in every cycle; results leave in the order the words came in and
// must be taken as they appear, as there is no way to hold them off. The pipeline is formed
// by a compare stage, a point selection stage and a multiply stage, then the 20-stage divider
// that forms the interpolation quotient, one bit per stage, and a result register. Calibration
// points are written through cfg_write, cfg_index and cfg_data while no word is in
// flight; indexes past the last point are ignored. busy is high only during reset.
module piecewise_linear_distance_lookup_core #(
  parameter int POINTS = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [plld_pkg::X_W-1:0]       width_q4,
  output logic                           done,
  output logic [plld_pkg::X_W-1:0]       distance_q4,
  input  logic                           cfg_write,
  input  logic [plld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plld_pkg::PT_W-1:0]      cfg_data
);

  localparam int XW = plld_pkg::X_W;

  logic [plld_pkg::PT_W-1:0] pts [plld_pkg::NREGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < plld_pkg::NREGS; i++) begin
        pts[i] <= plld_pkg::PT_RESET[i];
      end
    end else if (cfg_write) begin
      for (int i = 0; i < plld_pkg::NREGS; i++) begin
        if (cfg_index == plld_pkg::CFG_IDX_W'(i)) begin
          pts[i] <= cfg_data;
        end
      end
    end
  end

  assign busy = rst;

  // stage 1: compare the width against every point
  logic              s1_valid;
  logic [XW-1:0]     s1_x;
  logic [POINTS-1:0] s1_le;
  logic [POINTS-1:0] s1_ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_x <= width_q4;
    for (int i = 0; i < POINTS; i++) begin
      s1_le[i] <= plld_pkg::pt_width(pts[i]) <= width_q4;
      s1_ge[i] <= plld_pkg::pt_width(pts[i]) >= width_q4;
    end
  end

  // stage 2: pick the bracketing points, scan stops at the first point at or above
  logic          lo_ok, hi_ok, exact;
  logic [XW-1:0] x1, x2, y1, y2;
  logic [XW-1:0] dx_next, den_next, dy_next, base_next;
  logic          neg_next;

  always_comb begin
    lo_ok = 1'b0;
    hi_ok = 1'b0;
    exact = 1'b0;
    x1    = '0;
    x2    = '0;
    y1    = '0;
    y2    = '0;
    for (int i = 0; i < POINTS; i++) begin
      if (!hi_ok) begin
        if (s1_le[i]) begin
          lo_ok = 1'b1;
          x1    = plld_pkg::pt_width(pts[i]);
          y1    = plld_pkg::pt_dist(pts[i]);
        end
        if (s1_ge[i]) begin
          hi_ok = 1'b1;
          exact = s1_le[i];
          x2    = plld_pkg::pt_width(pts[i]);
          y2    = plld_pkg::pt_dist(pts[i]);
        end
      end
    end

    // direct answers go through the divider as base plus zero over one
    dx_next   = '0;
    den_next  = XW'(1);
    dy_next   = '0;
    neg_next  = 1'b0;
    base_next = y1;
    if (s1_x == '0) begin
      base_next = '0;
    end else if (!lo_ok) begin
      base_next = plld_pkg::pt_dist(pts[0]);
    end else if (!hi_ok) begin
      base_next = plld_pkg::pt_dist(pts[POINTS-1]);
    end else if (exact) begin
      base_next = y1;
    end else begin
      dx_next  = s1_x - x1;
      den_next = x2 - x1;
      if (y2 >= y1) begin
        dy_next = y2 - y1;
      end else begin
        neg_next = 1'b1;
        dy_next  = y1 - y2;
      end
    end
  end

  logic          s2_valid;
  logic [XW-1:0] s2_dx, s2_den, s2_dy, s2_base;
  logic          s2_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_dx   <= dx_next;
    s2_den  <= den_next;
    s2_dy   <= dy_next;
    s2_neg  <= neg_next;
    s2_base <= base_next;
  end

  // stage 3: slope numerator
  plld_pkg::div_ctl_t          s3_ctl;
  logic [plld_pkg::PROD_W-1:0] s3_prod;
  logic [XW-1:0]               s3_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl <= '0;
    end else begin
      s3_ctl.valid <= s2_valid;
      s3_ctl.neg   <= s2_neg;
      s3_ctl.base  <= s2_base;
    end
  end

  always_ff @(posedge clk) begin
    s3_prod <= plld_pkg::PROD_W'(s2_dy) * plld_pkg::PROD_W'(s2_dx);
    s3_den  <= s2_den;
  end

  plld_pkg::div_ctl_t div_ctl;
  logic [XW-1:0]      div_quo;

  plld_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (s3_ctl),
    .dividend (s3_prod),
    .divisor  (s3_den),
    .out_ctl  (div_ctl),
    .quotient (div_quo)
  );

  // result word, quotient already truncated toward zero on the magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    distance_q4 <= div_ctl.neg ? div_ctl.base - div_quo : div_ctl.base + div_quo;
  end

endmodule
